// ===== rtl/vtd_pkg.sv =====
`default_nettype none

package vtd_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned INDEX_BITS  = 16;

  // widths fixed by the request and result fields
  localparam int unsigned IDX_PORT_W = 16;
  localparam int unsigned SLOT_OUT_W = 8;

  // only the low INDEX_BITS of each index take part in the match
  localparam int unsigned CMP_BITS = (INDEX_BITS < IDX_PORT_W) ? INDEX_BITS : IDX_PORT_W;

  typedef logic [CMP_BITS-1:0] cmp_idx_t;

  typedef struct packed {
    cmp_idx_t pos;
    cmp_idx_t tex;
    cmp_idx_t nrm;
  } triple_t;

  // request travelling along the cell chain
  typedef struct packed {
    logic                  valid;
    logic                  start;
    triple_t               key;
    logic                  done;
    logic                  is_new;
    logic [SLOT_OUT_W-1:0] slot;
  } token_t;

endpackage

`default_nettype wire

// ===== rtl/vtd_cell.sv =====
`default_nettype none

module vtd_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic [vtd_pkg::SLOT_OUT_W-1:0] idx_i,
  input  wire vtd_pkg::token_t               tok_i,
  output vtd_pkg::token_t                    tok_o
);
  import vtd_pkg::*;

  logic    ent_valid_q, ent_valid_d;
  triple_t entry_q;
  token_t  tok_q, tok_d;
  logic    clear, live, hit, claim;

  always_comb begin
    clear = tok_i.valid && tok_i.start;
    // a start request empties this cell before it looks at it
    live  = ent_valid_q && !clear;
    hit   = tok_i.valid && !tok_i.done && live && (entry_q == tok_i.key);
    // entries fill in order, so the first empty cell is the next free slot
    claim = tok_i.valid && !tok_i.done && !live;

    ent_valid_d = live || claim;

    tok_d = tok_i;
    if (hit) begin
      tok_d.done   = 1'b1;
      tok_d.is_new = 1'b0;
      tok_d.slot   = idx_i;
    end else if (claim) begin
      tok_d.done   = 1'b1;
      tok_d.is_new = 1'b1;
      tok_d.slot   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      tok_q       <= '0;
    end else if (adv_i) begin
      ent_valid_q <= ent_valid_d;
      tok_q       <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && claim) begin
      entry_q <= tok_i.key;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== rtl/vertex_triple_dedup_unit.sv =====
`default_nettype none

// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+---------------------------------------
// request  | in        | in_valid_i / in_stall_o   | start_model, position/texcoord/normal
// result   | out       | out_valid_o / out_stall_i | vertex_slot, is_new, table_full
//
// one request enters per cycle while in_stall_o is low; each result is offered from the output register
// once its request has walked the TABLE_DEPTH cells, one after another
// requests follow each other at least one cell apart, so each one sees the table left by those before it
// reset empties the table and drops everything in flight; the table needs no clearing pass
// while a result waits and the output is stalled, the whole chain holds and requests are stalled

module vertex_triple_dedup_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           start_model_i,
  input  wire logic [vtd_pkg::IDX_PORT_W-1:0] position_index_i,
  input  wire logic [vtd_pkg::IDX_PORT_W-1:0] texcoord_index_i,
  input  wire logic [vtd_pkg::IDX_PORT_W-1:0] normal_index_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [vtd_pkg::SLOT_OUT_W-1:0]      vertex_slot_o,
  output logic                                is_new_o,
  output logic                                table_full_o
);
  import vtd_pkg::*;

  token_t chain [TABLE_DEPTH+1];
  token_t head_tok;
  logic   adv;

  logic                  out_valid_q, out_valid_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic                  new_q, new_d;
  logic                  full_q, full_d;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    head_tok         = '0;
    head_tok.valid   = in_valid_i;
    head_tok.start   = start_model_i;
    head_tok.key.pos = position_index_i[CMP_BITS-1:0];
    head_tok.key.tex = texcoord_index_i[CMP_BITS-1:0];
    head_tok.key.nrm = normal_index_i[CMP_BITS-1:0];
  end

  assign chain[0] = head_tok;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    vtd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .idx_i  (SLOT_OUT_W'(k)),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  // a request that found neither a match nor a free cell is an overflow
  always_comb begin
    out_valid_d = chain[TABLE_DEPTH].valid;
    slot_d      = chain[TABLE_DEPTH].done ? chain[TABLE_DEPTH].slot : '0;
    new_d       = chain[TABLE_DEPTH].done && chain[TABLE_DEPTH].is_new;
    full_d      = !chain[TABLE_DEPTH].done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      slot_q <= slot_d;
      new_q  <= new_d;
      full_q <= full_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_slot_o = slot_q;
  assign is_new_o      = new_q;
  assign table_full_o  = full_q;

  a_new_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(new_q && full_q))
    else $error("result both new and overflow");

  a_full_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && full_q |-> slot_q == '0)
    else $error("overflow result with nonzero slot");

  a_new_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[TABLE_DEPTH].valid && chain[TABLE_DEPTH].is_new |-> chain[TABLE_DEPTH].done)
    else $error("request marked new without claiming a cell");

  a_undone_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[TABLE_DEPTH].valid && !chain[TABLE_DEPTH].done |-> chain[TABLE_DEPTH].slot == '0)
    else $error("unresolved request carries a slot");

endmodule

`default_nettype wire
